@@ sv/ase_pkg.sv @@
package ase_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'd27;
  localparam logic [7:0] CLOSE_BYTE = 8'd109;
  localparam logic [7:0] TICK_BYTE  = 8'd96;
  localparam logic [7:0] LF_BYTE    = 8'd10;
  localparam logic [7:0] CR_BYTE    = 8'd13;
  localparam logic [7:0] SPACE_BYTE = 8'd32;
  localparam logic [7:0] ZERO_CHAR  = 8'd48;
  localparam logic [7:0] NINE_CHAR  = 8'd57;

  localparam logic [2:0] TAG_BEATS   = 3'd5;
  localparam logic [2:0] PLAIN_BEATS = 3'd1;

  // result of one input byte: nothing, one plain byte or a five-beat tag
  typedef struct packed {
    logic        emit;
    logic        tag;
    logic [7:0]  data;
    logic [23:0] body;   // tag characters, first one in the low byte
  } ase_result_t;

  typedef struct packed {
    logic        hit;
    logic [23:0] body;
  } ase_tag_t;

  function automatic logic [3:0] digit_value(input logic [7:0] b);
    logic [7:0] d;
    d = b - ZERO_CHAR;
    if (b >= ZERO_CHAR && b <= NINE_CHAR) begin
      return d[3:0];
    end
    return 4'd0;
  endfunction

  function automatic logic [23:0] chars3(input logic [7:0] c0, input logic [7:0] c1,
                                         input logic [7:0] c2);
    return {c2, c1, c0};
  endfunction

  // colour tag body for a code; no hit when second digit is 1 and code is not 31
  function automatic ase_tag_t colour_tag(input logic [3:0] first, input logic [3:0] second);
    ase_tag_t t;
    t.hit  = 1'b1;
    t.body = chars3("7", "7", "7");
    if (first == 4'd3 && second >= 4'd1 && second <= 4'd6) begin
      case (second)
        4'd1:    t.body = chars3("6", "0", "0");
        4'd2:    t.body = chars3("0", "6", "0");
        4'd3:    t.body = chars3("6", "6", "0");
        4'd4:    t.body = chars3("0", "0", "6");
        4'd5:    t.body = chars3("6", "0", "6");
        default: t.body = chars3("0", "5", "6");
      endcase
    end else if (second == 4'd1) begin
      t.hit = 1'b0;
    end
    return t;
  endfunction

endpackage

@@ sv/ase_decode.sv @@
module ase_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 add_colors,
  input  logic                 advance,
  input  logic [7:0]           item_byte,
  input  logic                 item_eos,
  output ase_pkg::ase_result_t res
);

  logic       in_escape, in_escape_next;
  logic [1:0] escape_offset, escape_offset_next;
  logic [3:0] first_digit, first_digit_next;
  logic [3:0] second_digit, second_digit_next;
  ase_pkg::ase_tag_t tag;

  assign tag = ase_pkg::colour_tag(first_digit_next, second_digit_next);

  always_comb begin
    in_escape_next     = in_escape;
    escape_offset_next = escape_offset;
    first_digit_next   = first_digit;
    second_digit_next  = second_digit;
    res.emit = 1'b0;
    res.tag  = 1'b0;
    res.data = item_byte;
    res.body = tag.body;
    if (item_byte == ase_pkg::ESC_BYTE) begin
      in_escape_next     = 1'b1;
      escape_offset_next = 2'd0;
      first_digit_next   = 4'd0;
      second_digit_next  = 4'd0;
    end else if (!in_escape) begin
      res.emit = 1'b1;
      if (item_byte == ase_pkg::LF_BYTE || item_byte == ase_pkg::CR_BYTE) begin
        res.data = ase_pkg::SPACE_BYTE;
      end
    end else begin
      if (escape_offset != 2'd3) begin
        escape_offset_next = escape_offset + 2'd1;
        if (escape_offset == 2'd1) begin
          first_digit_next = ase_pkg::digit_value(item_byte);
        end else if (escape_offset == 2'd2) begin
          second_digit_next = ase_pkg::digit_value(item_byte);
        end
      end
      if (item_byte == ase_pkg::CLOSE_BYTE) begin
        in_escape_next = 1'b0;
        if (add_colors && tag.hit) begin
          res.emit = 1'b1;
          res.tag  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_escape     <= 1'b0;
      escape_offset <= 2'd0;
      first_digit   <= 4'd0;
      second_digit  <= 4'd0;
    end else if (advance) begin
      if (item_eos) begin
        in_escape     <= 1'b0;
        escape_offset <= 2'd0;
        first_digit   <= 4'd0;
        second_digit  <= 4'd0;
      end else begin
        in_escape     <= in_escape_next;
        escape_offset <= escape_offset_next;
        first_digit   <= first_digit_next;
        second_digit  <= second_digit_next;
      end
    end
  end

  a_offset_clear: assert property (@(posedge clk) disable iff (rst)
    advance && item_byte == ase_pkg::ESC_BYTE |=> escape_offset == 2'd0)
    else $error("offset not cleared by esc");

  a_eos_clear: assert property (@(posedge clk) disable iff (rst)
    advance && item_eos |=> !in_escape && first_digit == 4'd0 && second_digit == 4'd0)
    else $error("state not cleared at end of string");

  a_tag_inside: assert property (@(posedge clk) disable iff (rst)
    res.tag |-> in_escape && add_colors)
    else $error("tag outside escape sequence");

endmodule

@@ sv/ase_emit.sv @@
module ase_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ase_pkg::ase_result_t res,
  output logic                 free,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,
  output logic                 m_axis_tlast
);

  logic [2:0]  cnt;
  logic        tag;
  logic [7:0]  data;
  logic [23:0] body;

  assign m_axis_tvalid = cnt != 3'd0;
  assign m_axis_tlast  = cnt == 3'd1;
  assign free          = cnt == 3'd0 || (cnt == 3'd1 && m_axis_tready);

  // beats remaining pick the tag character
  always_comb begin
    m_axis_tdata = data;
    if (tag) begin
      case (cnt)
        3'd4:    m_axis_tdata = body[7:0];
        3'd3:    m_axis_tdata = body[15:8];
        3'd2:    m_axis_tdata = body[23:16];
        default: m_axis_tdata = ase_pkg::TICK_BYTE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (load) begin
      cnt <= res.tag ? ase_pkg::TAG_BEATS : ase_pkg::PLAIN_BEATS;
    end else if (m_axis_tvalid && m_axis_tready) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tag  <= res.tag;
      data <= res.data;
      body <= res.body;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result loaded over a pending beat");

  a_tag_len: assert property (@(posedge clk) disable iff (rst)
    load && res.tag |=> cnt == ase_pkg::TAG_BEATS)
    else $error("tag does not start with five beats");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(cnt))
    else $error("beat count moved while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= ase_pkg::TAG_BEATS && (tag || cnt <= 3'd1 || load))
    else $error("beat count out of range");

endmodule

@@ sv/ansi_escape_stripper.sv @@
// channel  | dir | tdata            | tlast
// s_axis   | in  | [7:0] in_byte    | end_of_string
// m_axis   | out | [7:0] out_byte   | run_last
// cfg      | in  | cfg_wdata = add_colors, written when cfg_we is high
//
// one byte accepted per cycle unless the output stalls; a plain byte leaves via both registers
// a colour tag holds the output register for five beats; an emitted byte waits in
// the input register meanwhile, so the input stalls until the tag's last beat is taken
// dropped bytes (inside a sequence) pass the input register without waiting
// rst is synchronous and empties both registers, clears the escape state and add_colors
module ansi_escape_stripper (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  logic       add_colors;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eos;
  logic       s1_take;
  logic       emit_free;
  ase_pkg::ase_result_t res;

  assign s1_take       = s1_valid && (!res.emit || emit_free);
  assign s_axis_tready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      add_colors <= 1'b0;
    end else if (cfg_we) begin
      add_colors <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_byte <= s_axis_tdata;
      s1_eos  <= s_axis_tlast;
    end
  end

  ase_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .add_colors (add_colors),
    .advance    (s1_take),
    .item_byte  (s1_byte),
    .item_eos   (s1_eos),
    .res        (res)
  );

  ase_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .load          (s1_take && res.emit),
    .res           (res),
    .free          (emit_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
